/* hw/rtl/fpp_pkg.sv */
// Shared types and constants for the fill-pattern pixel plotter.
`default_nettype none

package fpp_pkg;

    // Configuration register indexes, in the order of the register map.
    typedef enum logic [2:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_TOP    = 3'd1,
        CFG_CLIP_RIGHT  = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_DRAW_COLOR  = 3'd4,
        CFG_FILL_PAT    = 3'd5,
        CFG_PALETTE     = 3'd6
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Item actions.
    localparam logic ACT_PLOT = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Bit positions inside the colour and fill-pattern words.
    localparam int COLOR_OVERRIDE_BIT = 28;
    localparam int COLOR_TRANSP_BIT   = 24;
    localparam int FILL_TRANSP_BIT    = 15;

    // Reset values of the configuration registers.
    localparam logic [7:0]  CLIP_LEFT_RST   = 8'd0;
    localparam logic [7:0]  CLIP_TOP_RST    = 8'd0;
    localparam logic [7:0]  CLIP_RIGHT_RST  = 8'd128;
    localparam logic [7:0]  CLIP_BOTTOM_RST = 8'd128;
    localparam logic [63:0] PALETTE_RST     = 64'hFEDC_BA98_7654_3210;

    // Decoded drawing state handed from the register block to the locate unit.
    typedef struct packed {
        logic [7:0]  clip_left;
        logic [7:0]  clip_top;
        logic [7:0]  clip_right;
        logic [7:0]  clip_bottom;
        logic [15:0] pattern;
        logic        transparent;
        logic [3:0]  color_pri;
        logic [3:0]  color_sec;
    } plot_cfg_t;

    // Per-item decision from the locate unit.
    typedef struct packed {
        logic       in_clip;
        logic       hi_nibble;
        logic       write_en;
        logic [3:0] color;
    } loc_t;

endpackage : fpp_pkg

`default_nettype wire

/* hw/rtl/fpp_if.sv */
// Valid/ready channel interfaces for pixel items and read results.
`default_nettype none

interface fpp_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;

    modport source (output valid, output action, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input action, input x_pos, input y_pos, output ready);
endinterface : fpp_in_if

interface fpp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface : fpp_out_if

`default_nettype wire

/* hw/rtl/fpp_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : fpp_ram

`default_nettype wire

/* hw/rtl/fpp_cfg.sv */
// Configuration registers and decode of colours, pattern and transparency.
`default_nettype none

module fpp_cfg
    import fpp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output plot_cfg_t                  plot_cfg
);

    logic [7:0]  clip_left_reg;
    logic [7:0]  clip_top_reg;
    logic [7:0]  clip_right_reg;
    logic [7:0]  clip_bottom_reg;
    logic [31:0] draw_color_reg;
    logic [31:0] fill_pat_reg;
    logic [63:0] palette_reg;

    // Register writes, decoded by index; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= CLIP_LEFT_RST;
            clip_top_reg    <= CLIP_TOP_RST;
            clip_right_reg  <= CLIP_RIGHT_RST;
            clip_bottom_reg <= CLIP_BOTTOM_RST;
            draw_color_reg  <= '0;
            fill_pat_reg    <= '0;
            palette_reg     <= PALETTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data[7:0];
                CFG_CLIP_TOP:    clip_top_reg    <= cfg_data[7:0];
                CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[7:0];
                CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[7:0];
                CFG_DRAW_COLOR:  draw_color_reg  <= cfg_data[31:0];
                CFG_FILL_PAT:    fill_pat_reg    <= cfg_data[31:0];
                CFG_PALETTE:     palette_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Pattern source follows the override flag; colours go through the palette.
    always_comb
    begin
        plot_cfg.clip_left   = clip_left_reg;
        plot_cfg.clip_top    = clip_top_reg;
        plot_cfg.clip_right  = clip_right_reg;
        plot_cfg.clip_bottom = clip_bottom_reg;
        if (draw_color_reg[COLOR_OVERRIDE_BIT])
        begin
            plot_cfg.pattern     = draw_color_reg[15:0];
            plot_cfg.transparent = draw_color_reg[COLOR_TRANSP_BIT];
        end
        else
        begin
            plot_cfg.pattern     = fill_pat_reg[31:16];
            plot_cfg.transparent = fill_pat_reg[FILL_TRANSP_BIT];
        end
        plot_cfg.color_pri = palette_reg[{draw_color_reg[19:16], 2'b00} +: 4];
        plot_cfg.color_sec = palette_reg[{draw_color_reg[23:20], 2'b00} +: 4];
    end

endmodule : fpp_cfg

`default_nettype wire

/* hw/rtl/fpp_locate.sv */
// Clip test, store address and fill-pattern decision for one coordinate.
`default_nettype none

module fpp_locate
    import fpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128,
    parameter int ADDR_W        = 13
) (
    input  wire logic               action,
    input  wire logic signed [31:0] x_pos,
    input  wire logic signed [31:0] y_pos,
    input  plot_cfg_t               plot_cfg,
    output loc_t                    loc,
    output logic [ADDR_W-1:0]       addr
);

    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int PIX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
    localparam logic [15:0] W16 = 16'(SCREEN_WIDTH);
    localparam logic [15:0] H16 = 16'(SCREEN_HEIGHT);

    logic [15:0]      ux;
    logic [15:0]      uy;
    logic [15:0]      right_lim;
    logic [15:0]      bottom_lim;
    logic             in_x;
    logic             in_y;
    logic [XW-1:0]    xi;
    logic [YW-1:0]    yi;
    logic [PIX_W-1:0] lin;
    logic             pat_bit;

    // Integer parts; a negative coordinate is never inside.
    assign ux = x_pos[31:16];
    assign uy = y_pos[31:16];

    // Clip bounds limited to the screen.
    assign right_lim  = ({8'd0, plot_cfg.clip_right} < W16) ? {8'd0, plot_cfg.clip_right} : W16;
    assign bottom_lim = ({8'd0, plot_cfg.clip_bottom} < H16) ? {8'd0, plot_cfg.clip_bottom} : H16;

    assign in_x = !x_pos[31] && (ux >= {8'd0, plot_cfg.clip_left}) && (ux < right_lim);
    assign in_y = !y_pos[31] && (uy >= {8'd0, plot_cfg.clip_top}) && (uy < bottom_lim);

    assign xi = ux[XW-1:0];
    assign yi = uy[YW-1:0];

    // Linear pixel index; two pixels share a byte.
    assign lin = PIX_W'(32'(yi) * 32'(SCREEN_WIDTH)) + PIX_W'(xi);

    assign pat_bit = plot_cfg.pattern[{yi[1:0], xi[1:0]}];

    // Plot decision: a set pattern bit draws the secondary colour unless transparent.
    always_comb
    begin
        loc.in_clip   = in_x && in_y;
        loc.hi_nibble = xi[0];
        loc.write_en  = loc.in_clip && (action == ACT_PLOT) &&
                        !(pat_bit && plot_cfg.transparent);
        loc.color     = pat_bit ? plot_cfg.color_sec : plot_cfg.color_pri;
        addr          = loc.in_clip ? ADDR_W'(lin >> 1) : '0;
    end

endmodule : fpp_locate

`default_nettype wire

/* hw/rtl/fill_pattern_pixel_plotter.sv */
// Top level of the fill-pattern pixel plotter: framebuffer, pipeline and ports.
//
// Each item plots or reads one 4-bit pixel of a SCREEN_WIDTH x SCREEN_HEIGHT
// framebuffer held in one byte-wide RAM, two pixels to a byte. An item is
// taken in every cycle: the address is worked out and the RAM read issued in
// the cycle of acceptance; in the next cycle the byte is merged and written
// back (a plot), or the nibble goes to the output register once that is free
// (a read). The single RAM write port sets that rate; a plot to the byte that
// the next item reads is forwarded. Outside the clearing pass, input stalls
// only while a read result waits in a full output register. After reset the
// framebuffer is cleared by a pass over all (SCREEN_WIDTH*SCREEN_HEIGHT+1)/2
// bytes, 8192 with the default size, during which no item is accepted;
// configuration writes are taken at any time but must only change while no
// item is in flight.
`default_nettype none

module fill_pattern_pixel_plotter
    import fpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    fpp_in_if.sink                     pix_in,
    fpp_out_if.source                  pix_out
);

    localparam int STORE_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    plot_cfg_t         plot_cfg;
    loc_t              loc;
    logic [ADDR_W-1:0] loc_addr;

    logic              in_accept;
    logic              out_fire;
    logic              advance;
    logic              wr_fire;
    logic [7:0]        rd_data;
    logic [7:0]        cur_byte;
    logic [7:0]        merged_byte;
    logic [3:0]        read_nibble;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              s1_valid_reg;
    logic              s1_read_reg;
    logic              s1_inside_reg;
    logic              s1_hi_reg;
    logic              s1_wr_reg;
    logic [3:0]        s1_color_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_byte_reg;
    logic              out_valid_reg;
    logic [3:0]        out_color_reg;

    fpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .plot_cfg  (plot_cfg)
    );

    fpp_locate #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_locate (
        .action   (pix_in.action),
        .x_pos    (pix_in.x_pos),
        .y_pos    (pix_in.y_pos),
        .plot_cfg (plot_cfg),
        .loc      (loc),
        .addr     (loc_addr)
    );

    fpp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (in_accept),
        .rd_addr (loc_addr),
        .rd_data (rd_data)
    );

    // Handshakes: a read in the second stage waits only for a free output register.
    assign out_fire      = out_valid_reg && pix_out.ready;
    assign advance       = !s1_read_reg || !out_valid_reg || pix_out.ready;
    assign pix_in.ready  = !clr_active_reg && (!s1_valid_reg || advance);
    assign in_accept     = pix_in.valid && pix_in.ready;
    assign pix_out.valid = out_valid_reg;
    assign pix_out.pixel_color = out_color_reg;

    // Second stage: pick up the byte, forwarded if the previous item just wrote it.
    assign cur_byte    = fwd_hit_reg ? fwd_byte_reg : rd_data;
    assign merged_byte = s1_hi_reg ? {s1_color_reg, cur_byte[3:0]}
                                   : {cur_byte[7:4], s1_color_reg};
    assign read_nibble = !s1_inside_reg ? 4'd0 :
                         (s1_hi_reg ? cur_byte[7:4] : cur_byte[3:0]);
    assign wr_fire     = s1_valid_reg && s1_wr_reg;

    // RAM write port is shared by the clearing pass and plot write-back.
    assign ram_we    = clr_active_reg || wr_fire;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? 8'd0 : merged_byte;

    // Clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Second-stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_fire && (s1_addr_reg == loc_addr);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && s1_read_reg && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Second-stage and output payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_read_reg   <= (pix_in.action == ACT_READ);
            s1_inside_reg <= loc.in_clip;
            s1_hi_reg     <= loc.hi_nibble;
            s1_wr_reg     <= loc.write_en;
            s1_color_reg  <= loc.color;
            s1_addr_reg   <= loc_addr;
            fwd_byte_reg  <= merged_byte;
        end
        if (s1_valid_reg && s1_read_reg && advance)
        begin
            out_color_reg <= read_nibble;
        end
    end

endmodule : fill_pattern_pixel_plotter

`default_nettype wire
